// ===== hw/rtl/tbr_pkg.sv =====
// Shared types and constants for the triggered beat repeater.
// No dependencies; imported by the sequencer and the top level.
package tbr_pkg;

  localparam int LOOP_LENGTH_W = 15;
  localparam int REPEATS_W     = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 15;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REPEATS     = 2'd1;

  localparam logic [REPEATS_W-1:0] RESET_REPEATS = 8'd4;

  // Per-item control from the sequencer to the output stage
  typedef struct packed {
    logic play;  // output comes from the loop store
    logic fwd;   // read hits the entry written in the same transfer
  } tbr_ctl_t;

endpackage

// ===== hw/rtl/triggered_beat_repeater.sv =====
// Triggered beat repeater (audio stutter). Takes one sample per transfer and
// returns one sample per transfer, in order. A trigger restarts recording at
// store entry 0 and looped playback at position 0, and reloads the repeat
// count; the loop then plays 'repeats' times over loop_length samples before
// input passes through again. Throughput is one transfer per cycle while the
// output is not stalled: each item needs at most one store write and one store
// read, which the dual-port loop store serves every cycle. Output valid rises
// once the item has passed stage B (registered store read) and then the output
// register. Configuration writes (index 0 loop_length, index 1 repeats) are
// always ready; issue them only while the block is idle. The store needs no
// clearing after reset.
// Depends on tbr_pkg, tbr_seq and tbr_store.
module triggered_beat_repeater
  import tbr_pkg::*;
#(
  parameter int BUF_DEPTH    = 16384,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_trigger,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int LL_MOD = BUF_DEPTH % (1 << LOOP_LENGTH_W);
  localparam logic [LOOP_LENGTH_W-1:0] RESET_LOOP_LENGTH =
    (LL_MOD == 0) ? {LOOP_LENGTH_W{1'b1}} : LOOP_LENGTH_W'(LL_MOD);

  // Configuration registers
  logic [LOOP_LENGTH_W-1:0] loop_length_r;
  logic [REPEATS_W-1:0]     repeats_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_length_r <= RESET_LOOP_LENGTH;
      repeats_r     <= RESET_REPEATS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOOP_LENGTH: loop_length_r <= cfg_data[LOOP_LENGTH_W-1:0];
        CFG_REPEATS:     repeats_r     <= cfg_data[REPEATS_W-1:0];
        default:         ;
      endcase
    end
  end

  // Handshake: stage B holds the item whose store read is in flight
  logic in_xfer, b_adv;
  logic b_valid_r, out_valid_r;

  assign b_adv    = b_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !b_valid_r || b_adv;
  assign in_xfer  = in_valid && in_ready;

  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  tbr_ctl_t        ctl;
  logic [SAMPLE_WIDTH-1:0] rd_data;

  tbr_seq #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_xfer),
    .trigger     (in_trigger),
    .loop_length (loop_length_r),
    .repeats     (repeats_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .ctl         (ctl)
  );

  // Read only on a transfer, so a stalled item keeps its read data
  tbr_store #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_sample_in),
    .rd_en   (in_xfer),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tbr_ctl_t                b_ctl_r;
  logic [SAMPLE_WIDTH-1:0] b_sample_r;
  logic [SAMPLE_WIDTH-1:0] b_result;
  logic [SAMPLE_WIDTH-1:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (in_xfer) begin
      b_valid_r <= 1'b1;
    end else if (b_adv) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      b_ctl_r    <= ctl;
      b_sample_r <= in_sample_in;
    end
  end

  // Pick loop or pass-through; forward the sample written in the same transfer
  always_comb begin
    if (b_ctl_r.play && !b_ctl_r.fwd) begin
      b_result = rd_data;
    end else begin
      b_result = b_sample_r;
    end
  end

  // Output register: drop valid once transferred, load on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_sample_r <= b_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

// ===== hw/rtl/tbr_store.sv =====
// Loop sample store: one write port, one read port, registered read data.
// No dependencies.
module tbr_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] loop_mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      loop_mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read so a stalled item keeps its sample
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= loop_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tbr_seq.sv =====
// Record/play position sequencer: tracks positions, run state and repeats left.
// Depends on tbr_pkg.
module tbr_seq
  import tbr_pkg::*;
#(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic                     trigger,
  input  logic [LOOP_LENGTH_W-1:0] loop_length,
  input  logic [REPEATS_W-1:0]     repeats,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [AW-1:0]            rd_addr,
  output tbr_ctl_t                 ctl
);

  localparam int LW = (AW + 1 > LOOP_LENGTH_W) ? AW + 1 : LOOP_LENGTH_W;
  localparam logic [AW:0] DEPTH_P = (AW + 1)'(DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

  logic [AW:0]          rec_r, rec_nxt, rec_cur;
  logic [AW-1:0]        pp_r, pp_nxt, pp_cur;
  logic                 run_r, run_nxt, run_cur;
  logic [REPEATS_W-1:0] rl_r, rl_nxt, rl_cur;
  logic [LW-1:0]        ll_ext, len, pp_inc;
  logic                 play, rec_ok;

  always_comb begin
    rec_cur = trigger ? '0 : rec_r;
    pp_cur  = trigger ? '0 : pp_r;
    run_cur = trigger | run_r;
    rl_cur  = trigger ? repeats : rl_r;

    // Clamp loop length to 1..DEPTH
    ll_ext = LW'(loop_length);
    if (ll_ext == '0) begin
      len = LW'(1);
    end else if (ll_ext > DEPTH_L) begin
      len = DEPTH_L;
    end else begin
      len = ll_ext;
    end

    rec_ok = rec_cur < DEPTH_P;
    play   = run_cur && ((rl_cur != '0) || (pp_cur != '0));
    pp_inc = LW'(pp_cur) + LW'(1);

    rec_nxt = rec_ok ? rec_cur + (AW + 1)'(1) : rec_cur;
    run_nxt = run_cur;
    rl_nxt  = (play && pp_cur == '0) ? rl_cur - REPEATS_W'(1) : rl_cur;
    if (play) begin
      pp_nxt = (pp_inc >= len) ? '0 : pp_inc[AW-1:0];
    end else begin
      pp_nxt = pp_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
      pp_r  <= '0;
      run_r <= 1'b0;
      rl_r  <= RESET_REPEATS;
    end else if (accept) begin
      rec_r <= rec_nxt;
      pp_r  <= pp_nxt;
      run_r <= run_nxt;
      rl_r  <= rl_nxt;
    end
  end

  assign wr_en    = accept && rec_ok;
  assign wr_addr  = rec_cur[AW-1:0];
  assign rd_addr  = pp_cur;
  assign ctl.play = play;
  assign ctl.fwd  = rec_ok && (rec_cur[AW-1:0] == pp_cur);

endmodule
